// File: hw/rtl/ppd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Packed pattern event decoder package
// Shared types and constants: configuration bundle, event word, parser phases
// and the register map of the configuration port.
// ----------------------------------------------------------------------------
package ppd_pkg;

	// Number of optional fields that can follow a flag byte.
	localparam int unsigned NUM_FIELDS = 6;

	// Configuration port geometry.
	localparam int unsigned APB_ADDR_W = 5;
	localparam int unsigned APB_DATA_W = 32;

	// Register indexes (byte address divided by four).
	localparam logic [2:0] REG_CHANNEL_COUNT     = 3'd0;
	localparam logic [2:0] REG_KEY_OFF_CODE      = 3'd1;
	localparam logic [2:0] REG_REVERSE_CODE      = 3'd2;
	localparam logic [2:0] REG_EXTENDED_CODE     = 3'd3;
	localparam logic [2:0] REG_CUT_SUBCODE       = 3'd4;
	localparam logic [2:0] REG_TRACK_VOLUME_CODE = 3'd5;
	localparam logic [2:0] REG_BPM_CODE          = 3'd6;

	// Register reset values.
	localparam logic [6:0] RST_CHANNEL_COUNT     = 7'd4;
	localparam logic [7:0] RST_KEY_OFF_CODE      = 8'd129;
	localparam logic [7:0] RST_REVERSE_CODE      = 8'd144;
	localparam logic [7:0] RST_EXTENDED_CODE     = 8'd14;
	localparam logic [3:0] RST_CUT_SUBCODE       = 4'd12;
	localparam logic [7:0] RST_TRACK_VOLUME_CODE = 8'd128;
	localparam logic [7:0] RST_BPM_CODE          = 8'd135;

	// Stream encoding constants.
	localparam logic [7:0] KEY_OFF_BYTE   = 8'h1f;
	localparam logic [7:0] NOTE_BASE      = 8'd13;
	localparam logic [7:0] SEMITONES      = 8'd12;
	localparam logic [7:0] FX_EXT_CMD     = 8'h0e;
	localparam logic [7:0] FX_REAL_BPM    = 8'h1c;
	localparam logic [7:0] TRACK_ON_PARAM = 8'h40;

	// Sub-commands of the extended effect (parameter high nibble).
	localparam logic [3:0] EXT_REVERSE      = 4'h3;
	localparam logic [3:0] EXT_SOUND_OFF    = 4'h4;
	localparam logic [3:0] EXT_TRACK_VOLUME = 4'h5;

	// Input command codes.
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_DATA  = 1'b1;

	typedef enum logic [2:0] {
		PH_CHANNEL    = 3'd0,
		PH_FLAGS      = 3'd1,
		PH_NOTE       = 3'd2,
		PH_INSTRUMENT = 3'd3,
		PH_FX1_TYPE   = 3'd4,
		PH_FX1_PARAM  = 3'd5,
		PH_FX2_TYPE   = 3'd6,
		PH_FX2_PARAM  = 3'd7
	} phase_t;

	typedef struct packed {
		logic [6:0] channel_count;
		logic [7:0] key_off_code;
		logic [7:0] reverse_code;
		logic [7:0] extended_code;
		logic [3:0] cut_subcode;
		logic [7:0] track_volume_code;
		logic [7:0] bpm_code;
	} cfg_t;

	typedef struct packed {
		logic [5:0]  channel;
		logic [15:0] row;
		logic [7:0]  note;
		logic [7:0]  instrument;
		logic [7:0]  fx1_type;
		logic [7:0]  fx1_param;
		logic [7:0]  fx2_type;
		logic [7:0]  fx2_param;
	} event_t;

endpackage
`default_nettype wire

// File: hw/rtl/ppd_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the decoder's code and channel settings.
// ----------------------------------------------------------------------------
module ppd_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ppd_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [ppd_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [ppd_pkg::APB_DATA_W-1:0]  prdata,
	output ppd_pkg::cfg_t                   cfg
);
	import ppd_pkg::*;

	logic       wr_en;
	logic [2:0] reg_idx;
	cfg_t       cfg_q;

	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_count     <= RST_CHANNEL_COUNT;
			cfg_q.key_off_code      <= RST_KEY_OFF_CODE;
			cfg_q.reverse_code      <= RST_REVERSE_CODE;
			cfg_q.extended_code     <= RST_EXTENDED_CODE;
			cfg_q.cut_subcode       <= RST_CUT_SUBCODE;
			cfg_q.track_volume_code <= RST_TRACK_VOLUME_CODE;
			cfg_q.bpm_code          <= RST_BPM_CODE;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CHANNEL_COUNT:     cfg_q.channel_count     <= pwdata[6:0];
				REG_KEY_OFF_CODE:      cfg_q.key_off_code      <= pwdata[7:0];
				REG_REVERSE_CODE:      cfg_q.reverse_code      <= pwdata[7:0];
				REG_EXTENDED_CODE:     cfg_q.extended_code     <= pwdata[7:0];
				REG_CUT_SUBCODE:       cfg_q.cut_subcode       <= pwdata[3:0];
				REG_TRACK_VOLUME_CODE: cfg_q.track_volume_code <= pwdata[7:0];
				REG_BPM_CODE:          cfg_q.bpm_code          <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CHANNEL_COUNT:     prdata = APB_DATA_W'(cfg_q.channel_count);
			REG_KEY_OFF_CODE:      prdata = APB_DATA_W'(cfg_q.key_off_code);
			REG_REVERSE_CODE:      prdata = APB_DATA_W'(cfg_q.reverse_code);
			REG_EXTENDED_CODE:     prdata = APB_DATA_W'(cfg_q.extended_code);
			REG_CUT_SUBCODE:       prdata = APB_DATA_W'(cfg_q.cut_subcode);
			REG_TRACK_VOLUME_CODE: prdata = APB_DATA_W'(cfg_q.track_volume_code);
			REG_BPM_CODE:          prdata = APB_DATA_W'(cfg_q.bpm_code);
			default:               prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// File: hw/rtl/ppd_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pattern stream parser
// Walks the packed byte stream one word per step, tracks budget and row, and
// assembles the raw event fields before effect remapping.
// ----------------------------------------------------------------------------
module ppd_parser #(
	parameter int unsigned MAX_CHANNELS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                command,
	input  logic [7:0]          data_byte,
	input  logic [15:0]         pattern_rows,
	input  logic [30:0]         pattern_bytes,
	input  ppd_pkg::cfg_t       cfg,
	output logic                emit,
	output ppd_pkg::event_t     ev
);
	import ppd_pkg::*;

	localparam logic [2:0] FIELD_NONE = 3'(NUM_FIELDS);

	phase_t      phase_q, phase_d;
	logic [30:0] budget_q, budget_d, budget_dec;
	logic [15:0] row_q, row_d;
	logic [15:0] row_limit_q, row_limit_d;
	logic [7:0]  chan_q, chan_d;
	logic [5:0]  flags_q, flags_d, flags_eff;
	logic [7:0]  fields_q [NUM_FIELDS];
	logic [7:0]  fields_d [NUM_FIELDS];
	logic [2:0]  field_idx, search_from, nxt;
	logic [7:0]  note_val;
	logic        live, event_done, in_range;

	// Lowest selected field at or after the given position.
	function automatic logic [2:0] next_field(input logic [5:0] flags, input logic [2:0] from);
		logic [2:0] r;
		r = FIELD_NONE;
		for (int i = NUM_FIELDS - 1; i >= 0; i--) begin
			if (flags[i] && (3'(i) >= from)) begin
				r = 3'(i);
			end
		end
		return r;
	endfunction

	assign live        = (command == CMD_DATA) && (budget_q != '0);
	assign budget_dec  = budget_q - 31'd1;
	assign field_idx   = 3'(phase_q - PH_NOTE);
	assign flags_eff   = (phase_q == PH_FLAGS) ? data_byte[5:0] : flags_q;
	assign search_from = (phase_q == PH_FLAGS) ? 3'd0 : 3'(field_idx + 3'd1);
	assign nxt         = next_field(flags_eff, search_from);
	assign event_done  = (nxt == FIELD_NONE) || (budget_dec == '0);

	assign note_val = (data_byte == KEY_OFF_BYTE) ? cfg.key_off_code
		: 8'(NOTE_BASE + 8'({4'd0, data_byte[7:4]} * SEMITONES) + 8'({4'd0, data_byte[3:0]}));

	assign in_range = (chan_q < {1'b0, cfg.channel_count})
		&& (9'(chan_q) < 9'(MAX_CHANNELS))
		&& (row_q < row_limit_q);

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (step) begin
			if (command == CMD_START) begin
				phase_d = PH_CHANNEL;
			end else if (live) begin
				unique case (phase_q)
					PH_CHANNEL: begin
						if ((data_byte != '0) && (budget_dec != '0)) begin
							phase_d = PH_FLAGS;
						end
					end
					default: begin
						phase_d = event_done ? PH_CHANNEL : phase_t'(3'(PH_NOTE) + nxt);
					end
				endcase
			end
		end
	end

	// Datapath updates and event output.
	always_comb begin
		budget_d    = budget_q;
		row_d       = row_q;
		row_limit_d = row_limit_q;
		chan_d      = chan_q;
		flags_d     = flags_q;
		fields_d    = fields_q;
		emit        = 1'b0;
		if (step) begin
			if (command == CMD_START) begin
				row_limit_d = pattern_rows;
				budget_d    = pattern_bytes;
				row_d       = '0;
				flags_d     = '0;
				for (int i = 0; i < NUM_FIELDS; i++) begin
					fields_d[i] = '0;
				end
			end else if (live) begin
				budget_d = budget_dec;
				if (phase_q == PH_CHANNEL) begin
					if (data_byte == '0) begin
						if (row_q != 16'hffff) begin
							row_d = row_q + 16'd1;
						end
					end else begin
						chan_d = data_byte - 8'd1;
					end
				end else begin
					if (phase_q == PH_FLAGS) begin
						flags_d = data_byte[5:0];
						for (int i = 0; i < NUM_FIELDS; i++) begin
							fields_d[i] = '0;
						end
					end else begin
						for (int i = 0; i < NUM_FIELDS; i++) begin
							if (field_idx == 3'(i)) begin
								fields_d[i] = (i == 0) ? note_val : data_byte;
							end
						end
					end
					emit = event_done && in_range;
				end
			end
		end
	end

	assign ev.channel    = chan_q[5:0];
	assign ev.row        = row_q;
	assign ev.note       = fields_d[0];
	assign ev.instrument = fields_d[1];
	assign ev.fx1_type   = fields_d[2];
	assign ev.fx1_param  = fields_d[3];
	assign ev.fx2_type   = fields_d[4];
	assign ev.fx2_param  = fields_d[5];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_CHANNEL;
			budget_q    <= '0;
			row_q       <= '0;
			row_limit_q <= '0;
			chan_q      <= '0;
			flags_q     <= '0;
			for (int i = 0; i < NUM_FIELDS; i++) begin
				fields_q[i] <= '0;
			end
		end else begin
			phase_q     <= phase_d;
			budget_q    <= budget_d;
			row_q       <= row_d;
			row_limit_q <= row_limit_d;
			chan_q      <= chan_d;
			flags_q     <= flags_d;
			fields_q    <= fields_d;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/ppd_fx_remap.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Effect remap
// Translates one effect type/parameter pair into the target effect codes.
// ----------------------------------------------------------------------------
module ppd_fx_remap (
	input  logic          note_present,
	input  logic [7:0]    in_type,
	input  logic [7:0]    in_param,
	input  ppd_pkg::cfg_t cfg,
	output logic [7:0]    out_type,
	output logic [7:0]    out_param
);
	import ppd_pkg::*;

	always_comb begin
		out_type  = in_type;
		out_param = in_param;
		if (in_type == FX_EXT_CMD) begin
			unique case (in_param[7:4])
				EXT_REVERSE: begin
					// Play-backward only makes sense when a note starts.
					out_type  = note_present ? cfg.reverse_code : 8'd0;
					out_param = note_present ? 8'd1 : 8'd0;
				end
				EXT_SOUND_OFF: begin
					out_type  = cfg.extended_code;
					out_param = {cfg.cut_subcode, 4'd0};
				end
				EXT_TRACK_VOLUME: begin
					out_type  = cfg.track_volume_code;
					out_param = (in_param != '0) ? TRACK_ON_PARAM : 8'd0;
				end
				default: ;
			endcase
		end else if (in_type == FX_REAL_BPM) begin
			out_type = cfg.bpm_code;
		end else if (in_type > FX_REAL_BPM) begin
			out_type  = 8'd0;
			out_param = 8'd0;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/packed_pattern_event_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Packed pattern event decoder
// Turns a byte-packed tracker pattern stream into note event words.
// ----------------------------------------------------------------------------
// The decoder takes one input word per clock cycle unless input is refused
// as said below. An accepted word sits in an input register, where the
// parser decodes it, updates the pattern state and remaps the effects in a
// single pass; an event goes to a result register that drives the output
// channel. Input is refused only while the result register holds an event
// that has not been taken and the input register holds a word waiting to
// be decoded, so a steady stream runs at one word per cycle whenever the
// output side keeps up.
// A start word loads the pattern's row count and byte budget and clears the
// row counter; data words then walk through channel, flag and field bytes.
// Events on a channel at or above channel_count or MAX_CHANNELS, or on a row
// at or above the pattern's row count, are dropped. The configuration port is
// APB-style with pready tied high; registers lie at byte offsets 0x00 to 0x18
// and should only be written while no word is in flight.
// ----------------------------------------------------------------------------
module packed_pattern_event_decoder #(
	parameter int unsigned MAX_CHANNELS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ppd_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [ppd_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [ppd_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	// input words
	input  logic                            item_valid,
	output logic                            item_ready,
	input  logic                            command,
	input  logic [7:0]                      data_byte,
	input  logic [15:0]                     pattern_rows,
	input  logic [30:0]                     pattern_bytes,
	// event words
	output logic                            event_valid,
	input  logic                            event_ready,
	output logic [5:0]                      channel,
	output logic [15:0]                     row,
	output logic [7:0]                      note,
	output logic [7:0]                      instrument,
	output logic [7:0]                      fx1_type,
	output logic [7:0]                      fx1_param,
	output logic [7:0]                      fx2_type,
	output logic [7:0]                      fx2_param
);
	import ppd_pkg::*;

	cfg_t        cfg;
	event_t      raw_ev, map_ev, ev_s2;
	logic        emit;
	logic        advance;
	logic        valid_s1;
	logic        command_s1;
	logic [7:0]  data_byte_s1;
	logic [15:0] pattern_rows_s1;
	logic [30:0] pattern_bytes_s1;
	logic        event_valid_s2;

	assign pready = 1'b1;

	ppd_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg    (cfg)
	);

	// The word in the input register is decoded once the result register is
	// free or being emptied this cycle; a new word enters then or if none waits.
	assign advance    = valid_s1 && (!event_valid_s2 || event_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload of the input register needs no reset.
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			command_s1       <= command;
			data_byte_s1     <= data_byte;
			pattern_rows_s1  <= pattern_rows;
			pattern_bytes_s1 <= pattern_bytes;
		end
	end

	ppd_parser #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.command      (command_s1),
		.data_byte    (data_byte_s1),
		.pattern_rows (pattern_rows_s1),
		.pattern_bytes(pattern_bytes_s1),
		.cfg          (cfg),
		.emit         (emit),
		.ev           (raw_ev)
	);

	// Both effect pairs are remapped in parallel; the note decides whether a
	// play-backward command survives.
	ppd_fx_remap u_fx1 (
		.note_present(raw_ev.note != '0),
		.in_type     (raw_ev.fx1_type),
		.in_param    (raw_ev.fx1_param),
		.cfg         (cfg),
		.out_type    (map_ev.fx1_type),
		.out_param   (map_ev.fx1_param)
	);

	ppd_fx_remap u_fx2 (
		.note_present(raw_ev.note != '0),
		.in_type     (raw_ev.fx2_type),
		.in_param    (raw_ev.fx2_param),
		.cfg         (cfg),
		.out_type    (map_ev.fx2_type),
		.out_param   (map_ev.fx2_param)
	);

	assign map_ev.channel    = raw_ev.channel;
	assign map_ev.row        = raw_ev.row;
	assign map_ev.note       = raw_ev.note;
	assign map_ev.instrument = raw_ev.instrument;

	// Result register: holds an event until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_valid_s2 <= 1'b0;
		end else if (advance && emit) begin
			event_valid_s2 <= 1'b1;
		end else if (event_ready) begin
			event_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			ev_s2 <= map_ev;
		end
	end

	assign event_valid = event_valid_s2;
	assign channel     = ev_s2.channel;
	assign row         = ev_s2.row;
	assign note        = ev_s2.note;
	assign instrument  = ev_s2.instrument;
	assign fx1_type    = ev_s2.fx1_type;
	assign fx1_param   = ev_s2.fx1_param;
	assign fx2_type    = ev_s2.fx2_type;
	assign fx2_param   = ev_s2.fx2_param;

endmodule
`default_nettype wire

// File: hw/rtl/ppd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Decoder port checker
// Watches the decoder's ports for handshake and flow-control slips.
// ----------------------------------------------------------------------------
module ppd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        command,
	input logic        event_valid,
	input logic        event_ready,
	input logic [5:0]  channel,
	input logic [15:0] row,
	input logic [7:0]  note,
	input logic [7:0]  instrument,
	input logic [7:0]  fx1_type,
	input logic [7:0]  fx1_param,
	input logic [7:0]  fx2_type,
	input logic [7:0]  fx2_param
);

	// A stalled event word stays offered.
	a_event_hold: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && !event_ready |=> event_valid)
		else $error("event word withdrawn before it was taken");

	// A stalled event word keeps its payload.
	a_event_stable: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && !event_ready |=> $stable(channel) && $stable(row)
			&& $stable(note) && $stable(instrument) && $stable(fx1_type)
			&& $stable(fx1_param) && $stable(fx2_type) && $stable(fx2_param))
		else $error("event word changed while stalled");

	// Input is refused only under output back-pressure.
	a_ready_only_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> event_valid && !event_ready)
		else $error("input refused without output back-pressure");

	// A fresh event stems from a data word accepted earlier.
	a_event_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(event_valid) |-> $past(item_valid && item_ready && command, 2))
		else $error("event appeared without a matching data word");

endmodule

bind packed_pattern_event_decoder ppd_checker u_ppd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item_valid),
	.item_ready (item_ready),
	.command    (command),
	.event_valid(event_valid),
	.event_ready(event_ready),
	.channel    (channel),
	.row        (row),
	.note       (note),
	.instrument (instrument),
	.fx1_type   (fx1_type),
	.fx1_param  (fx1_param),
	.fx2_type   (fx2_type),
	.fx2_param  (fx2_param)
);
`default_nettype wire
